[rtl/amb_pkg.sv]
// Shared constants, widths and helpers for the accelerometer magnitude band filter.
// No dependencies; imported by the result and coefficient interfaces, amb_isqrt and the top level.
`default_nettype none

package amb_pkg;

   // Default values of the top-level parameters.
   localparam int DEF_SAMPLE_BITS = 16;
   localparam int DEF_COEF_BITS   = 16;
   localparam int DEF_FRAC_BITS   = 4;

   // Fixed widths of the filter path.
   localparam int VAL_BITS  = 22;
   localparam int MAG_BITS  = 20;
   localparam int WIDE_BITS = VAL_BITS + 2;

   // Saturation limits of a filter value, held at the wide width.
   localparam logic signed [WIDE_BITS-1:0] VAL_MAX_WIDE = WIDE_BITS'(2 ** (VAL_BITS - 1) - 1);
   localparam logic signed [WIDE_BITS-1:0] VAL_MIN_WIDE = WIDE_BITS'(-(2 ** (VAL_BITS - 1)));

   // Coefficient register map.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HIGHPASS_COEFF = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOWPASS_COEFF  = CSR_INDEX_BITS'(1);

   // Coefficient reset values (Q0.16 fractions of one).
   localparam int HP_COEF_RESET = 63537;
   localparam int LP_COEF_RESET = 10388;

   // Clamp a wide signed value to the signed filter range.
   function automatic logic signed [VAL_BITS-1:0] sat_val(input logic signed [WIDE_BITS-1:0] v);
      logic signed [WIDE_BITS-1:0] c;
      priority if (v > VAL_MAX_WIDE) begin
         c = VAL_MAX_WIDE;
      end else if (v < VAL_MIN_WIDE) begin
         c = VAL_MIN_WIDE;
      end else begin
         c = v;
      end
      return signed'(c[VAL_BITS-1:0]);
   endfunction

endpackage

`default_nettype wire

[rtl/amb_req_if.sv]
// Sample request channel: valid/ready handshake with three signed axis readings.
// Depends on nothing but its width parameter.
`default_nettype none

interface amb_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] accel_x;
   logic signed [SAMPLE_BITS-1:0] accel_y;
   logic signed [SAMPLE_BITS-1:0] accel_z;

   modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
   modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

`default_nettype wire

[rtl/amb_rsp_if.sv]
// Result channel: valid/ready handshake carrying the filtered magnitude.
// Depends on amb_pkg for the value width.
`default_nettype none

interface amb_rsp_if;
   import amb_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [VAL_BITS-1:0] filtered_magnitude;

   modport source (output valid, output filtered_magnitude, input ready);
   modport sink   (input valid, input filtered_magnitude, output ready);
endinterface

`default_nettype wire

[rtl/amb_csr_if.sv]
// Coefficient write channel: valid/ready handshake with register index and data.
// Depends on amb_pkg for the index width.
`default_nettype none

interface amb_csr_if #(
   parameter int DATA_BITS = 16
);
   import amb_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [DATA_BITS-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/amb_mul.sv]
// Shared signed multiplier with a registered product, used for the squares and both filters.
// Standalone; no package dependency.
`default_nettype none

module amb_mul #(
   parameter int A_BITS = 24,
   parameter int B_BITS = 17
) (
   input  wire logic                              clock,
   input  wire logic signed [A_BITS-1:0]          op_a,
   input  wire logic signed [B_BITS-1:0]          op_b,
   output      logic signed [A_BITS+B_BITS-1:0]   product
);

   logic signed [A_BITS+B_BITS-1:0] product_ff;
   logic signed [A_BITS+B_BITS-1:0] product_in;

   // Full-precision product; operands are selected by the sequencer every cycle.
   always_comb begin
      product_in = (A_BITS + B_BITS)'(op_a) * (A_BITS + B_BITS)'(op_b);
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

`default_nettype wire

[rtl/amb_isqrt.sv]
// Iterative integer square root, one root bit per cycle (restoring digit recurrence).
// Depends on amb_pkg only through the import convention; widths come from ROOT_BITS.
`default_nettype none

module amb_isqrt #(
   parameter int ROOT_BITS = 21
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [2*ROOT_BITS-1:0]   radicand,
   output      logic                     done,
   output      logic [ROOT_BITS-1:0]     root
);
   import amb_pkg::*;

   localparam int RAD_BITS = 2 * ROOT_BITS;
   localparam int CNT_BITS = $clog2(ROOT_BITS);

   logic [RAD_BITS-1:0]  rad_ff,   rad_in;
   logic [ROOT_BITS-1:0] rem_ff,   rem_in;
   logic [ROOT_BITS-1:0] root_ff,  root_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 busy_ff,  busy_in;
   logic                 done_ff,  done_in;

   logic [ROOT_BITS+1:0] rem_shift;
   logic [ROOT_BITS+1:0] trial;
   logic [ROOT_BITS+1:0] rem_diff;

   // One recurrence step: bring down two radicand bits and try the next root bit.
   always_comb begin
      rem_shift = {rem_ff, rad_ff[RAD_BITS-1 -: 2]};
      trial     = {root_ff, 2'b01};
      rem_diff  = rem_shift - trial;

      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;

      if (start) begin
         rad_in   = radicand;
         rem_in   = '0;
         root_in  = '0;
         count_in = CNT_BITS'(ROOT_BITS - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rad_in = rad_ff << 2;
         if (rem_shift >= trial) begin
            rem_in  = rem_diff[ROOT_BITS-1:0];
            root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift[ROOT_BITS-1:0];
            root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
         end
         count_in = count_ff - CNT_BITS'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is reset; the datapath registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      count_ff <= count_in;
   end

   assign done = done_ff;
   assign root = root_ff;

`ifndef ASSERT_OFF
   // The root is announced only after the unit has been iterating.
   assert_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("square root finished without iterating");

   // A start launches the iteration on the next cycle.
   assert_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("square root start did not begin iterating");

   // Busy and done never overlap.
   assert_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("square root done while still busy");
`endif

endmodule

`default_nettype wire

[rtl/accel_magnitude_bandpass.sv]
// Accelerometer magnitude band filter: top level with sequencer and filter state.
// Depends on amb_pkg, the three channel interfaces, amb_mul and amb_isqrt.
`default_nettype none

// Takes one (x, y, z) sample per request and returns one band-filtered magnitude.
// The magnitude is the floored square root of x*x + y*y + z*z with FRAC_BITS
// fraction bits, followed by a first-order high-pass and a first-order low-pass
// filter whose Q0.16 coefficients are written through the csr channel
// (index 0 high-pass, index 1 low-pass; other indexes are ignored). Most of the time
// per sample goes to the square-root unit, which resolves one root bit per cycle;
// the rest goes to the three squares and two filter products on the single shared
// multiplier and their sequencing. The block takes no new request while a sample is
// in flight, but a finished result waits in the output register while the next
// request is accepted; if that result is still waiting when the next one is ready,
// the block holds until it is taken. Coefficients are to be written only while the
// block is idle.
module accel_magnitude_bandpass #(
   parameter int SAMPLE_BITS = amb_pkg::DEF_SAMPLE_BITS,
   parameter int COEF_BITS   = amb_pkg::DEF_COEF_BITS,
   parameter int FRAC_BITS   = amb_pkg::DEF_FRAC_BITS
) (
   input wire logic  clock,
   input wire logic  reset,
   amb_req_if.sink   req_bus,
   amb_rsp_if.source rsp_bus,
   amb_csr_if.sink   csr_bus
);
   import amb_pkg::*;

   localparam int SUM_BITS  = 2 * SAMPLE_BITS + 2;
   localparam int ROOT_BITS = SAMPLE_BITS + 1 + FRAC_BITS;
   localparam int RAD_BITS  = 2 * ROOT_BITS;
   localparam int MUL_A     = (SAMPLE_BITS > VAL_BITS) ? SAMPLE_BITS : VAL_BITS;
   localparam int MUL_B     = (SAMPLE_BITS > COEF_BITS + 1) ? SAMPLE_BITS : COEF_BITS + 1;
   localparam int PROD_BITS = MUL_A + MUL_B;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_MUL_Z,
      ST_ACC_Z,
      ST_ROOT,
      ST_HP_MUL,
      ST_HP_SAT,
      ST_LP_MUL,
      ST_LP_SUM
   } state_type;

   state_type state_ff, state_in;

   // Sample and accumulation registers.
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic signed [SAMPLE_BITS-1:0] y_ff, y_in;
   logic signed [SAMPLE_BITS-1:0] z_ff, z_in;
   logic [SUM_BITS-1:0]           sum_ff, sum_in;

   // Filter working registers.
   logic [MAG_BITS-1:0]           mag_ff, mag_in;
   logic signed [VAL_BITS-1:0]    acc_ff, acc_in;
   logic signed [VAL_BITS-1:0]    hp_new_ff, hp_new_in;

   // Filter state carried from sample to sample.
   logic [MAG_BITS-1:0]           last_mag_ff, last_mag_in;
   logic signed [VAL_BITS-1:0]    hp_ff, hp_in;
   logic signed [VAL_BITS-1:0]    lp_ff, lp_in;

   // Coefficient registers.
   logic [COEF_BITS-1:0]          hpc_ff, hpc_in;
   logic [COEF_BITS-1:0]          lpc_ff, lpc_in;

   // Output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_BITS-1:0]    rsp_data_ff, rsp_data_in;

   // Shared unit connections.
   logic signed [MUL_A-1:0]       mul_a;
   logic signed [MUL_B-1:0]       mul_b;
   logic signed [PROD_BITS-1:0]   product;
   logic                          root_start;
   logic [RAD_BITS-1:0]           radicand;
   logic                          root_done;
   logic [ROOT_BITS-1:0]          root;

   // Derived datapath values.
   logic [SUM_BITS-1:0]           sum_next;
   logic [ROOT_BITS+MAG_BITS-1:0] root_ext;
   logic [MAG_BITS-1:0]           mag_sat;
   logic signed [WIDE_BITS-1:0]   hp_sum;
   logic signed [PROD_BITS-1:0]   prod_shift;
   logic signed [WIDE_BITS-1:0]   prod_scaled;
   logic signed [VAL_BITS-1:0]    hp_result;
   logic signed [VAL_BITS-1:0]    lp_result;
   logic                          out_free;

   amb_mul #(
      .A_BITS (MUL_A),
      .B_BITS (MUL_B)
   ) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   amb_isqrt #(
      .ROOT_BITS (ROOT_BITS)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (radicand),
      .done     (root_done),
      .root     (root)
   );

   // Multiplier operand selection: squares first, then the two filter products.
   always_comb begin
      unique case (state_ff)
         ST_MUL_X: begin
            mul_a = MUL_A'(x_ff);
            mul_b = MUL_B'(x_ff);
         end
         ST_MUL_Y: begin
            mul_a = MUL_A'(y_ff);
            mul_b = MUL_B'(y_ff);
         end
         ST_MUL_Z: begin
            mul_a = MUL_A'(z_ff);
            mul_b = MUL_B'(z_ff);
         end
         ST_LP_MUL, ST_LP_SUM: begin
            mul_a = MUL_A'(acc_ff);
            mul_b = signed'(MUL_B'({1'b0, lpc_ff}));
         end
         default: begin
            mul_a = MUL_A'(acc_ff);
            mul_b = signed'(MUL_B'({1'b0, hpc_ff}));
         end
      endcase
   end

   // Arithmetic around the shared units.
   always_comb begin
      sum_next    = sum_ff + SUM_BITS'(product[2*SAMPLE_BITS-1:0]);
      radicand    = RAD_BITS'(sum_next) << (2 * FRAC_BITS);
      root_start  = (state_ff == ST_ACC_Z);

      root_ext    = (ROOT_BITS + MAG_BITS)'(root);
      mag_sat     = (|root_ext[ROOT_BITS+MAG_BITS-1:MAG_BITS]) ? '1 : root_ext[MAG_BITS-1:0];

      hp_sum      = WIDE_BITS'(hp_ff) + signed'(WIDE_BITS'(mag_sat))
                    - signed'(WIDE_BITS'(last_mag_ff));

      // Arithmetic shift is the floor of the Q0.COEF_BITS scaling.
      prod_shift  = product >>> COEF_BITS;
      prod_scaled = signed'(prod_shift[WIDE_BITS-1:0]);
      hp_result   = sat_val(prod_scaled);
      lp_result   = sat_val(WIDE_BITS'(lp_ff) + prod_scaled);

      out_free    = !rsp_valid_ff || rsp_bus.ready;
   end

   // Sequencer next state and register updates.
   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      sum_in       = sum_ff;
      mag_in       = mag_ff;
      acc_in       = acc_ff;
      hp_new_in    = hp_new_ff;
      last_mag_in  = last_mag_ff;
      hp_in        = hp_ff;
      lp_in        = lp_ff;
      hpc_in       = hpc_ff;
      lpc_in       = lpc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // The result slot empties when it is taken.
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Coefficient writes; unknown indexes are dropped.
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_HIGHPASS_COEFF: hpc_in = csr_bus.data;
            CSR_LOWPASS_COEFF:  lpc_in = csr_bus.data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               x_in     = req_bus.accel_x;
               y_in     = req_bus.accel_y;
               z_in     = req_bus.accel_z;
               sum_in   = '0;
               state_in = ST_MUL_X;
            end
         end
         ST_MUL_X: begin
            state_in = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            sum_in   = sum_next;
            state_in = ST_MUL_Z;
         end
         ST_MUL_Z: begin
            sum_in   = sum_next;
            state_in = ST_ACC_Z;
         end
         ST_ACC_Z: begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_done) begin
               mag_in   = mag_sat;
               acc_in   = sat_val(hp_sum);
               state_in = ST_HP_MUL;
            end
         end
         ST_HP_MUL: begin
            state_in = ST_HP_SAT;
         end
         ST_HP_SAT: begin
            hp_new_in = hp_result;
            acc_in    = sat_val(WIDE_BITS'(hp_result) - WIDE_BITS'(lp_ff));
            state_in  = ST_LP_MUL;
         end
         ST_LP_MUL: begin
            state_in = ST_LP_SUM;
         end
         ST_LP_SUM: begin
            // Commit only when the output register can take the result.
            if (out_free) begin
               lp_in        = lp_result;
               hp_in        = hp_new_ff;
               last_mag_in  = mag_ff;
               rsp_data_in  = lp_result;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, filter history, coefficients, sample and working registers, and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_mag_ff  <= '0;
         hp_ff        <= '0;
         lp_ff        <= '0;
         hpc_ff       <= COEF_BITS'(HP_COEF_RESET);
         lpc_ff       <= COEF_BITS'(LP_COEF_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_mag_ff  <= last_mag_in;
         hp_ff        <= hp_in;
         lp_ff        <= lp_in;
         hpc_ff       <= hpc_in;
         lpc_ff       <= lpc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      sum_ff      <= sum_in;
      mag_ff      <= mag_in;
      acc_ff      <= acc_in;
      hp_new_ff   <= hp_new_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_bus.ready              = (state_ff == ST_IDLE);
   assign csr_bus.ready              = 1'b1;
   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.filtered_magnitude = rsp_data_ff;

`ifndef ASSERT_OFF
   // An accepted request always starts the square sequence.
   assert_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> (state_ff == ST_MUL_X))
      else $error("accepted request did not start the sequence");

   // The root unit only reports while the sequencer waits for it.
   assert_root_in_wait: assert property (@(posedge clock) disable iff (reset)
      root_done |-> (state_ff == ST_ROOT))
      else $error("square root result arrived outside the wait state");

   // A new result appears only on the commit step of the low-pass filter.
   assert_result_from_commit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && rsp_bus.ready) && !$past(rsp_valid_ff))
      |-> $past(state_ff == ST_LP_SUM))
      else $error("result appeared without a filter commit");

   // Filter history changes only when a result is committed.
   assert_history_commit: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LP_SUM) |=> ($stable(lp_ff) && $stable(hp_ff) && $stable(last_mag_ff)))
      else $error("filter history changed outside a commit");
`endif

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Testbench for accel_magnitude_bandpass: directed table, then random phases of samples.
// Depends on amb_pkg, accel_magnitude_bandpass and its request, result and coefficient interfaces.
`timescale 1ns / 1ps

module tb_top;
   import amb_pkg::*;

   typedef logic signed [DEF_SAMPLE_BITS-1:0] axis_type;
   typedef logic signed [VAL_BITS-1:0]        band_type;
   typedef logic [DEF_COEF_BITS-1:0]          coef_type;
   typedef logic [CSR_INDEX_BITS-1:0]         csr_index_type;

   // Register indexes that decode to nothing.
   localparam csr_index_type CSR_SPARE_2 = csr_index_type'(2);
   localparam csr_index_type CSR_SPARE_3 = csr_index_type'(3);

   localparam axis_type AXIS_MAX  = 16'sh7FFF;
   localparam axis_type AXIS_MIN  = 16'sh8000;
   localparam axis_type AXIS_ZERO = 16'sh0000;
   localparam coef_type COEF_FULL = 16'hFFFF;
   localparam coef_type COEF_NONE = 16'h0000;

   localparam longint MAG_LIMIT = (longint'(1) << MAG_BITS) - 1;
   localparam longint BAND_MAX  = (longint'(1) << (VAL_BITS - 1)) - 1;
   localparam longint BAND_MIN  = -(longint'(1) << (VAL_BITS - 1));

   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 64;
   localparam int MAX_REPORTS = 10;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 92;

   typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      axis_type      x;
      axis_type      y;
      axis_type      z;
      csr_index_type index;
      coef_type      data;
      bit            has_value;
      band_type      value;
   } stim_row_type;

   // Directed part. Typed values are the cases where a zero coefficient or the reset state pins the output.
   localparam stim_row_type DIRECTED_ROWS [27] = '{
      '{ROW_SAMPLE, AXIS_ZERO, AXIS_ZERO, AXIS_ZERO, CSR_HIGHPASS_COEFF, '0, 1'b1, '0},
      '{ROW_WRITE,  AXIS_ZERO, AXIS_ZERO, AXIS_ZERO, CSR_HIGHPASS_COEFF, COEF_NONE, 1'b0, '0},
      '{ROW_SAMPLE, AXIS_MIN,  AXIS_MIN,  AXIS_MIN,  CSR_HIGHPASS_COEFF, '0, 1'b1, '0},
      '{ROW_SAMPLE, AXIS_MAX,  AXIS_MAX,  AXIS_MAX,  CSR_HIGHPASS_COEFF, '0, 1'b1, '0},
      '{ROW_WRITE,  AXIS_ZERO, AXIS_ZERO, AXIS_ZERO, CSR_HIGHPASS_COEFF, COEF_FULL, 1'b0, '0},
      '{ROW_WRITE,  AXIS_ZERO, AXIS_ZERO, AXIS_ZERO, CSR_LOWPASS_COEFF,  COEF_NONE, 1'b0, '0},
      '{ROW_SAMPLE, AXIS_MAX,  AXIS_MIN,  AXIS_MAX,  CSR_HIGHPASS_COEFF, '0, 1'b1, '0},
      '{ROW_SAMPLE, AXIS_ZERO, AXIS_ZERO, AXIS_ZERO, CSR_HIGHPASS_COEFF, '0, 1'b1, '0},
      '{ROW_WRITE,  AXIS_ZERO, AXIS_ZERO, AXIS_ZERO, CSR_LOWPASS_COEFF,  COEF_FULL, 1'b0, '0},
      '{ROW_WRITE,  AXIS_ZERO, AXIS_ZERO, AXIS_ZERO, CSR_HIGHPASS_COEFF,
        coef_type'(HP_COEF_RESET), 1'b0, '0},
      '{ROW_SAMPLE, AXIS_MAX,  AXIS_ZERO, AXIS_ZERO, CSR_HIGHPASS_COEFF, '0, 1'b0, '0},
      '{ROW_SAMPLE, AXIS_MIN,  AXIS_ZERO, AXIS_ZERO, CSR_HIGHPASS_COEFF, '0, 1'b0, '0},
      '{ROW_SAMPLE, AXIS_ZERO, AXIS_MAX,  AXIS_ZERO, CSR_HIGHPASS_COEFF, '0, 1'b0, '0},
      '{ROW_SAMPLE, AXIS_ZERO, AXIS_MIN,  AXIS_ZERO, CSR_HIGHPASS_COEFF, '0, 1'b0, '0},
      '{ROW_SAMPLE, AXIS_ZERO, AXIS_ZERO, AXIS_MAX,  CSR_HIGHPASS_COEFF, '0, 1'b0, '0},
      '{ROW_SAMPLE, AXIS_ZERO, AXIS_ZERO, AXIS_MIN,  CSR_HIGHPASS_COEFF, '0, 1'b0, '0},
      '{ROW_SAMPLE, AXIS_MIN,  AXIS_MIN,  AXIS_MIN,  CSR_HIGHPASS_COEFF, '0, 1'b0, '0},
      '{ROW_SAMPLE, AXIS_ZERO, AXIS_ZERO, AXIS_ZERO, CSR_HIGHPASS_COEFF, '0, 1'b0, '0},
      '{ROW_WRITE,  AXIS_ZERO, AXIS_ZERO, AXIS_ZERO, CSR_SPARE_2, COEF_FULL, 1'b0, '0},
      '{ROW_WRITE,  AXIS_ZERO, AXIS_ZERO, AXIS_ZERO, CSR_SPARE_3, COEF_NONE, 1'b0, '0},
      '{ROW_WRITE,  AXIS_ZERO, AXIS_ZERO, AXIS_ZERO, CSR_LOWPASS_COEFF,
        coef_type'(LP_COEF_RESET), 1'b0, '0},
      '{ROW_SAMPLE, -16'sd1,   16'sd1,    -16'sd1,   CSR_HIGHPASS_COEFF, '0, 1'b0, '0},
      '{ROW_SAMPLE, 16'sd1,    -16'sd1,   16'sd1,    CSR_HIGHPASS_COEFF, '0, 1'b0, '0},
      '{ROW_SAMPLE, 16'sd300,  -16'sd2000, 16'sd12345, CSR_HIGHPASS_COEFF, '0, 1'b0, '0},
      '{ROW_SAMPLE, AXIS_MIN,  AXIS_MIN,  AXIS_MIN,  CSR_HIGHPASS_COEFF, '0, 1'b0, '0},
      '{ROW_SAMPLE, AXIS_MIN,  AXIS_MIN,  AXIS_MIN,  CSR_HIGHPASS_COEFF, '0, 1'b0, '0},
      '{ROW_SAMPLE, AXIS_ZERO, AXIS_ZERO, AXIS_ZERO, CSR_HIGHPASS_COEFF, '0, 1'b0, '0}
   };

   localparam axis_type CORNER_VALUES [5] = '{AXIS_MIN, AXIS_MAX, AXIS_ZERO, -16'sd1, 16'sd1};

   logic clock;
   logic reset;

   amb_req_if #(.SAMPLE_BITS(DEF_SAMPLE_BITS)) req_bus ();
   amb_rsp_if                                  rsp_bus ();
   amb_csr_if #(.DATA_BITS(DEF_COEF_BITS))     csr_bus ();

   accel_magnitude_bandpass u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Filter state as the block should hold it.
   coef_type model_hp_coef = coef_type'(HP_COEF_RESET);
   coef_type model_lp_coef = coef_type'(LP_COEF_RESET);
   longint   model_prev_mag = 0;
   longint   model_highpass = 0;
   longint   model_lowpass  = 0;

   band_type expected_band_q [$];
   int       fail_count   = 0;
   int       results_seen = 0;
   int       burst_left   = 0;
   int       quiet_cycles = 0;

   // Sideband that travels with each request: a typed-in expected value, if any.
   bit       req_has_value   = 1'b0;
   band_type req_fixed_value = '0;

   logic [31:0] stall_pattern = '1;
   logic [4:0]  stall_slot    = '0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint clamp_band(input longint v);
      if (v > BAND_MAX) return BAND_MAX;
      if (v < BAND_MIN) return BAND_MIN;
      return v;
   endfunction

   // Floored square root, one result bit at a time from the top.
   function automatic longint unsigned floor_root(input longint unsigned n);
      longint unsigned root;
      longint unsigned probe;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         probe = root | (64'd1 << b);
         if (probe * probe <= n) root = probe;
      end
      return root;
   endfunction

   // Magnitude, then high-pass, then low-pass; advances the filter state.
   function automatic band_type predict_band_output(input axis_type x, input axis_type y,
                                                    input axis_type z);
      longint          sq_sum;
      longint unsigned root;
      longint          mag;
      longint          acc;
      longint          hp;
      longint          lp;
      sq_sum = longint'(x) * longint'(x) + longint'(y) * longint'(y)
             + longint'(z) * longint'(z);
      root = floor_root(longint'(unsigned'(sq_sum)) << (2 * DEF_FRAC_BITS));
      mag  = (root > MAG_LIMIT) ? MAG_LIMIT : longint'(root);
      acc  = clamp_band(model_highpass + mag - model_prev_mag);
      hp   = clamp_band((acc * longint'(model_hp_coef)) >>> DEF_COEF_BITS);
      acc  = clamp_band(hp - model_lowpass);
      lp   = clamp_band(model_lowpass + ((acc * longint'(model_lp_coef)) >>> DEF_COEF_BITS));
      model_prev_mag = mag;
      model_highpass = hp;
      model_lowpass  = lp;
      return band_type'(lp);
   endfunction

   task automatic note_failure(input string what);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("mismatch: %s", what);
   endtask

   // Offers one request, in bursts with random gaps, and waits until it is taken.
   task automatic send_sample(input axis_type x, input axis_type y, input axis_type z,
                              input bit has_value, input band_type value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
         burst_left = $urandom_range(1, 12);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid   <= 1'b1;
      req_bus.accel_x <= x;
      req_bus.accel_y <= y;
      req_bus.accel_z <= z;
      req_has_value   <= has_value;
      req_fixed_value <= value;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
   endtask

   // Holds the write valid high; the caller lowers it after the last write.
   task automatic write_register(input csr_index_type index, input coef_type data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
   endtask

   // Stops requests and waits until every outstanding result has come back.
   task automatic settle_idle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (expected_band_q.size() != 0);
   endtask

   // The result side stalls on its own 32-bit pattern, redrawn each time the slot counter wraps.
   always @(posedge clock) begin
      if (stall_slot == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pattern = '1;
            1: stall_pattern = $urandom | (32'd1 << $urandom_range(0, 31));
            2: stall_pattern = ($urandom & $urandom & $urandom)
                             | (32'd1 << $urandom_range(0, 31));
            default: stall_pattern = $urandom | $urandom | (32'd1 << $urandom_range(0, 31));
         endcase
      end
      rsp_bus.ready <= stall_pattern[stall_slot];
      stall_slot = stall_slot + 5'd1;
   end

   // Checks results, tracks register writes and predicts each accepted request.
   always @(posedge clock) begin : scoreboard
      band_type oldest;
      band_type predicted;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_band_q.size() == 0) begin
               note_failure($sformatf("result %0d arrived with no request outstanding",
                                      rsp_bus.filtered_magnitude));
            end else begin
               oldest = expected_band_q.pop_front();
               if (rsp_bus.filtered_magnitude !== oldest) begin
                  note_failure($sformatf("result %0d: expected %0d, got %0d", results_seen,
                                         oldest, rsp_bus.filtered_magnitude));
               end
            end
            results_seen++;
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_HIGHPASS_COEFF: model_hp_coef = csr_bus.data;
               CSR_LOWPASS_COEFF:  model_lp_coef = csr_bus.data;
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            predicted = predict_band_output(req_bus.accel_x, req_bus.accel_y, req_bus.accel_z);
            expected_band_q.push_back(req_has_value ? req_fixed_value : predicted);
         end
      end
   end

   // Watchdog: too long without any handshake ends the run.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      axis_type x;
      axis_type y;
      axis_type z;
      coef_type hp_val;
      coef_type lp_val;
      bit       prev_write;

      req_bus.valid   = 1'b0;
      req_bus.accel_x = '0;
      req_bus.accel_y = '0;
      req_bus.accel_z = '0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = CSR_HIGHPASS_COEFF;
      csr_bus.data    = '0;
      rsp_bus.ready   = 1'b0;
      reset           = 1'b1;
      x = '0;
      y = '0;
      z = '0;
      prev_write = 1'b0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed table; writes wait for the block to drain first.
      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].kind == ROW_WRITE) begin
            if (!prev_write) settle_idle();
            write_register(DIRECTED_ROWS[i].index, DIRECTED_ROWS[i].data);
            prev_write = 1'b1;
         end else begin
            if (prev_write) csr_bus.valid <= 1'b0;
            send_sample(DIRECTED_ROWS[i].x, DIRECTED_ROWS[i].y, DIRECTED_ROWS[i].z,
                        DIRECTED_ROWS[i].has_value, DIRECTED_ROWS[i].value);
            prev_write = 1'b0;
         end
      end

      // Random phases, each under its own pair of coefficients.
      for (int phase = 0; phase < PHASES; phase++) begin
         settle_idle();
         case (phase)
            0: begin hp_val = COEF_FULL;          lp_val = COEF_FULL;          end
            1: begin hp_val = COEF_NONE;          lp_val = coef_type'($urandom); end
            2: begin hp_val = 16'd1;              lp_val = 16'd1;              end
            3: begin hp_val = coef_type'($urandom); lp_val = COEF_NONE;        end
            4: begin hp_val = 16'h8000;           lp_val = COEF_FULL;          end
            5: begin
               hp_val = coef_type'(HP_COEF_RESET);
               lp_val = coef_type'(LP_COEF_RESET);
            end
            6: begin hp_val = coef_type'($urandom); lp_val = coef_type'($urandom); end
            default: begin hp_val = COEF_FULL;    lp_val = 16'd1;              end
         endcase
         if (phase % 3 == 2) begin
            write_register(CSR_SPARE_2, coef_type'($urandom));
            write_register(CSR_SPARE_3, coef_type'($urandom));
         end
         if ($urandom_range(0, 1) == 1) begin
            write_register(CSR_HIGHPASS_COEFF, hp_val);
            write_register(CSR_LOWPASS_COEFF, lp_val);
         end else begin
            write_register(CSR_LOWPASS_COEFF, lp_val);
            write_register(CSR_HIGHPASS_COEFF, hp_val);
         end
         csr_bus.valid <= 1'b0;

         repeat (PHASE_ITEMS) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  x = axis_type'($urandom);
                  y = axis_type'($urandom);
                  z = axis_type'($urandom);
               end
               4, 5: begin
                  // Small readings keep the magnitude near the bottom of its range.
                  x = axis_type'(int'($urandom_range(0, 127)) - 64);
                  y = axis_type'(int'($urandom_range(0, 127)) - 64);
                  z = axis_type'(int'($urandom_range(0, 127)) - 64);
               end
               6: begin
                  x = CORNER_VALUES[$urandom_range(0, 4)];
                  y = CORNER_VALUES[$urandom_range(0, 4)];
                  z = CORNER_VALUES[$urandom_range(0, 4)];
               end
               7, 8: ;  // Same sample again, so the high-pass output decays.
               default: begin
                  x = axis_type'($urandom);
                  y = axis_type'(int'($urandom_range(0, 31)) - 16);
                  z = axis_type'(int'($urandom_range(0, 31)) - 16);
               end
            endcase
            send_sample(x, y, z, 1'b0, '0);
         end
      end

      // Drain, then allow time for any stray result to show up.
      settle_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_band_q.size() != 0) begin
         note_failure($sformatf("%0d results never arrived", expected_band_q.size()));
      end
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
